// ----- rtl/bignum_short_division_assert.svh -----
`ifndef BIGNUM_SHORT_DIVISION_ASSERT_SVH
`define BIGNUM_SHORT_DIVISION_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bignum_short_division: assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define BSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bignum_short_division: assertion failed");

`endif

// ----- rtl/bsd_pkg.sv -----
package bsd_pkg;

    localparam int DIG_W          = 32;
    localparam int TRIM_W         = 7;
    localparam int MAX_DIGITS_DEF = 64;
    localparam int STEP_W         = $clog2(2 * DIG_W + 1);

    localparam logic [DIG_W-1:0] DIVISOR_RST = DIG_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- rtl/bsd_if.sv -----
interface bsd_in_if;
    import bsd_pkg::*;
    logic             valid;
    logic             ready;
    logic [DIG_W-1:0] digit;
    logic             last;
    modport source (output valid, output digit, output last, input ready);
    modport sink (input valid, input digit, input last, output ready);
endinterface

interface bsd_res_if;
    import bsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIG_W-1:0]  quotient_digit;
    logic              is_leading_zero;
    logic [DIG_W-1:0]  remainder_out;
    logic [TRIM_W-1:0] trimmed_size;
    logic              last_out;
    modport source (output valid, output quotient_digit, output is_leading_zero,
                    output remainder_out, output trimmed_size, output last_out,
                    input ready);
    modport sink (input valid, input quotient_digit, input is_leading_zero,
                  input remainder_out, input trimmed_size, input last_out,
                  output ready);
endinterface

interface bsd_cfg_if;
    import bsd_pkg::*;
    logic             valid;
    logic             ready;
    logic [DIG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bsd_div_unit.sv -----
module bsd_div_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [bsd_pkg::DIG_W-1:0] i_divisor,
    input  logic [bsd_pkg::DIG_W-1:0] i_carry,
    input  logic [bsd_pkg::DIG_W-1:0] i_digit,
    output bsd_pkg::t_div_sts         o_sts,
    output logic [bsd_pkg::DIG_W-1:0] o_quotient,
    output logic [bsd_pkg::DIG_W-1:0] o_remainder
);
    import bsd_pkg::*;

    logic [2*DIG_W-1:0] r_sr;
    logic [2*DIG_W-1:0] n_sr;
    logic [DIG_W-1:0]   r_prem;
    logic [DIG_W-1:0]   n_prem;
    logic [STEP_W-1:0]  r_cnt;
    logic [STEP_W-1:0]  n_cnt;
    logic               r_busy;
    logic               n_busy;
    logic               r_done;
    logic               n_done;
    logic [DIG_W:0]     w_rem;
    logic [DIG_W:0]     w_diff;
    logic               w_ge;

    // one restoring step: shift in the next dividend bit, trial subtract
    assign w_rem  = {r_prem, r_sr[2*DIG_W-1]};
    assign w_diff = w_rem - {1'b0, i_divisor};
    assign w_ge   = (w_rem >= {1'b0, i_divisor});

    always_comb begin
        n_sr   = r_sr;
        n_prem = r_prem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            if (i_divisor == '0) begin
                n_sr   = {{DIG_W{1'b0}}, {DIG_W{1'b1}}};
                n_prem = i_digit;
                n_cnt  = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (i_carry < i_divisor) begin
                n_sr   = {i_digit, {DIG_W{1'b0}}};
                n_prem = i_carry;
                n_cnt  = STEP_W'(DIG_W);
                n_busy = 1'b1;
                n_done = 1'b0;
            end else begin
                // carry not reduced: run all 64 bits, high quotient bits drop out
                n_sr   = {i_carry, i_digit};
                n_prem = '0;
                n_cnt  = STEP_W'(2 * DIG_W);
                n_busy = 1'b1;
                n_done = 1'b0;
            end
        end else if (r_busy) begin
            n_sr   = {r_sr[2*DIG_W-2:0], w_ge};
            n_prem = w_ge ? w_diff[DIG_W-1:0] : w_rem[DIG_W-1:0];
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr   <= n_sr;
        r_prem <= n_prem;
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_sr[DIG_W-1:0];
    assign o_remainder = r_prem;

endmodule

// ----- rtl/bignum_short_division.sv -----
// Each digit runs through a restoring divider, one quotient bit a cycle: the carried
// remainder and digit load when the digit is taken, then it steps through the digit's
// bits (carry and digit together if the carry is not below the divisor, none for a
// zero divisor); the next digit is taken in the cycle its result is registered.
// Reset (synchronous, active low): divisor returns to 1, carried remainder,
// leading-zero tracking and digit count clear, output and divider go idle.
module bignum_short_division #(
    parameter int MAX_DIGITS = bsd_pkg::MAX_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsd_in_if.sink    i_in,
    bsd_cfg_if.sink   i_cfg,
    bsd_res_if.source o_res
);
    import bsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    t_state            r_state;
    t_state            n_state;
    logic [DIG_W-1:0]  r_divisor;
    logic [DIG_W-1:0]  r_carry;
    logic [DIG_W-1:0]  n_carry;
    logic              r_seen;
    logic              n_seen;
    logic [CNT_W-1:0]  r_sig_cnt;
    logic [CNT_W-1:0]  n_sig_cnt;
    logic              r_last;
    logic              n_last;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [DIG_W-1:0]  r_q;
    logic [DIG_W-1:0]  n_q;
    logic              r_lead;
    logic              n_lead;
    logic [DIG_W-1:0]  r_rem_out;
    logic [DIG_W-1:0]  n_rem_out;
    logic [TRIM_W-1:0] r_trim;
    logic [TRIM_W-1:0] n_trim;
    logic              r_last_out;
    logic              n_last_out;
    logic              w_in_ready;
    logic              w_in_acc;
    logic              w_load;
    logic              w_seen;
    logic [CNT_W-1:0]  w_cnt;
    t_div_sts          w_sts;
    logic [DIG_W-1:0]  w_quot;
    logic [DIG_W-1:0]  w_rem;

    assign w_in_ready  = (r_state == ST_IDLE) ||
                         ((r_state == ST_DIV) && w_sts.done && (!r_out_valid || o_res.ready));
    assign w_in_acc    = i_in.valid && w_in_ready;
    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    assign w_seen = r_seen || (w_quot != '0);
    assign w_cnt  = (w_seen && (r_sig_cnt < CNT_W'(MAX_DIGITS))) ?
                    r_sig_cnt + CNT_W'(1) : r_sig_cnt;

    always_comb begin
        n_state     = r_state;
        n_carry     = r_carry;
        n_seen      = r_seen;
        n_sig_cnt   = r_sig_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_res.ready;
        n_q         = r_q;
        n_lead      = r_lead;
        n_rem_out   = r_rem_out;
        n_trim      = r_trim;
        n_last_out  = r_last_out;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_last  = i_in.last;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_sts.done && (!r_out_valid || o_res.ready)) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_q         = w_quot;
                    n_lead      = !w_seen;
                    n_rem_out   = r_last ? w_rem : '0;
                    n_trim      = r_last ? TRIM_W'(w_cnt) : '0;
                    n_last_out  = r_last;
                    if (r_last) begin
                        n_carry   = '0;
                        n_seen    = 1'b0;
                        n_sig_cnt = '0;
                    end else begin
                        n_carry   = w_rem;
                        n_seen    = w_seen;
                        n_sig_cnt = w_cnt;
                    end
                    if (w_in_acc) begin
                        n_last  = i_in.last;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    bsd_div_unit u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc),
        .i_divisor   (r_divisor),
        .i_carry     (n_carry),
        .i_digit     (i_in.digit),
        .o_sts       (w_sts),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_divisor   <= DIVISOR_RST;
            r_carry     <= '0;
            r_seen      <= 1'b0;
            r_sig_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_carry     <= n_carry;
            r_seen      <= n_seen;
            r_sig_cnt   <= n_sig_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_divisor <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_q        <= n_q;
        r_lead     <= n_lead;
        r_rem_out  <= n_rem_out;
        r_trim     <= n_trim;
        r_last_out <= n_last_out;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.quotient_digit  = r_q;
    assign o_res.is_leading_zero = r_lead;
    assign o_res.remainder_out   = r_rem_out;
    assign o_res.trimmed_size    = r_trim;
    assign o_res.last_out        = r_last_out;

`include "bignum_short_division_assert.svh"

    `BSD_ASSERT_NEXT(a_acc_starts_div, w_in_acc, r_state == ST_DIV && w_sts.busy || w_sts.done)
    `BSD_ASSERT_NEXT(a_carry_reduced, w_load && !r_last && r_divisor != '0, r_carry < $past(r_divisor))
    `BSD_ASSERT_NOW(a_cnt_bounded, 1'b1, r_sig_cnt <= CNT_W'(MAX_DIGITS))
    `BSD_ASSERT_NOW(a_tail_only_on_last, r_out_valid && !r_last_out, r_rem_out == '0 && r_trim == '0)

endmodule
